// ===== rtl/one_wire_bus_master_assert.svh =====
// assertion macros shared by the one-wire master
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication
`define OWBM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("owbm assertion failed");

// next-cycle implication
`define OWBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("owbm assertion failed");

`endif

// ===== rtl/owbm_pkg.sv =====
`default_nettype none

package owbm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_WAIT_LOW  = 4'd2,
        PH_WAIT_HIGH = 4'd3,
        PH_RST_FAIL  = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_HIGH   = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_SAMPLE = 4'd8,
        PH_RD_REC    = 4'd9
    } phase_t;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIME_W     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DLY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WR_ZERO_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WR_ZERO_REC   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WR_ONE_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WR_ONE_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd7;

    localparam logic [4:0] LOW_POLL_LIMIT  = 5'd20;
    localparam logic [4:0] HIGH_POLL_LIMIT = 5'd24;
    localparam logic [7:0] READ_RECOVERY   = 8'd40;
    localparam logic [TIME_W-1:0] READ_REC_LOAD = TIME_W'(READ_RECOVERY - 8'd1);

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_delay;
        logic [7:0] poll_interval;
        logic [7:0] write_zero_low;
        logic [7:0] write_zero_recovery;
        logic [7:0] write_one_low;
        logic [7:0] write_one_high;
        logic [7:0] read_low_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_low_time:      10'd520,
        presence_delay:      8'd15,
        poll_interval:       8'd10,
        write_zero_low:      8'd70,
        write_zero_recovery: 8'd2,
        write_one_low:       8'd9,
        write_one_high:      8'd55,
        read_low_time:       8'd15
    };

    typedef struct packed {
        logic       kind;
        logic [1:0] command;
        logic [7:0] write_value;
        logic       line_level;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_value;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/owbm_regs.sv =====
`default_nettype none

module owbm_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               wr_en,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]    wr_data,
    output owbm_pkg::cfg_t                          cfg
);
    import owbm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_RESET_LOW:     cfg_next.reset_low_time      = wr_data;
                REG_PRESENCE_DLY:  cfg_next.presence_delay      = wr_data[7:0];
                REG_POLL_INTERVAL: cfg_next.poll_interval       = wr_data[7:0];
                REG_WR_ZERO_LOW:   cfg_next.write_zero_low      = wr_data[7:0];
                REG_WR_ZERO_REC:   cfg_next.write_zero_recovery = wr_data[7:0];
                REG_WR_ONE_LOW:    cfg_next.write_one_low       = wr_data[7:0];
                REG_WR_ONE_HIGH:   cfg_next.write_one_high      = wr_data[7:0];
                REG_READ_LOW:      cfg_next.read_low_time       = wr_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/owbm_core.sv =====
`default_nettype none

module owbm_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire owbm_pkg::item_t item,
    input  wire owbm_pkg::cfg_t  cfg,
    output owbm_pkg::result_t   res
);
    import owbm_pkg::*;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] time_cnt;
        logic [2:0]        bit_idx;
        logic [7:0]        shift;
        logic              done;
    } slot_t;

    // first write slot from idx on that has nonzero time; zero slots pass at once
    function automatic slot_t write_slot(input logic [2:0] idx, input logic [7:0] sh,
                                         input cfg_t c);
        slot_t      r;
        logic       found;
        logic       b;
        logic [3:0] pos;
        logic [7:0] lo;
        logic [7:0] hi;
        r.phase    = PH_IDLE;
        r.time_cnt = '0;
        r.bit_idx  = 3'd7;
        r.shift    = sh;
        r.done     = 1'b1;
        found      = 1'b0;
        for (int k = 0; k < 8; k++) begin
            pos = {1'b0, idx} + 4'(k);
            b   = sh[k];
            lo  = b ? c.write_one_low  : c.write_zero_low;
            hi  = b ? c.write_one_high : c.write_zero_recovery;
            if (!found && pos <= 4'd7 && (lo != 8'd0 || hi != 8'd0)) begin
                found     = 1'b1;
                r.bit_idx = pos[2:0];
                r.shift   = sh >> k;
                r.done    = 1'b0;
                if (lo != 8'd0) begin
                    r.phase    = PH_WR_LOW;
                    r.time_cnt = {2'b00, lo};
                end else begin
                    r.phase    = PH_WR_HIGH;
                    r.time_cnt = {2'b00, hi};
                end
            end
        end
        return r;
    endfunction

    phase_t            phase_reg,     phase_next;
    logic [TIME_W-1:0] time_reg,      time_next;
    logic [2:0]        bit_reg,       bit_next;
    logic [7:0]        shift_reg,     shift_next;
    logic [4:0]        poll_reg,      poll_next;
    logic              presence_reg,  presence_next;
    logic [7:0]        last_read_reg, last_read_next;
    logic              done_next;

    logic              expire;
    logic [TIME_W-1:0] time_dec;
    logic [7:0]        wr_rel;
    logic [7:0]        sampled;
    slot_t             first_slot;
    slot_t             follow_slot;

    assign expire      = (time_reg <= TIME_W'(1));
    assign time_dec    = (time_reg == '0) ? '0 : time_reg - TIME_W'(1);
    assign wr_rel      = shift_reg[0] ? cfg.write_one_high : cfg.write_zero_recovery;
    assign sampled     = {item.line_level, shift_reg[7:1]};
    assign first_slot  = write_slot(3'd0, item.write_value, cfg);
    assign follow_slot = write_slot(bit_reg + 3'd1, shift_reg >> 1, cfg);

    // next state
    always_comb begin
        phase_next     = phase_reg;
        time_next      = time_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        done_next      = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (item.kind == KIND_CMD) begin
                case (item.command)
                    CMD_RESET: begin
                        bit_next = 3'd0;
                        if (cfg.reset_low_time != '0) begin
                            phase_next = PH_RST_LOW;
                            time_next  = cfg.reset_low_time;
                        end else begin
                            phase_next = PH_WAIT_LOW;
                            time_next  = {2'b00, cfg.presence_delay};
                            poll_next  = '0;
                        end
                    end
                    CMD_WRITE: begin
                        phase_next = first_slot.phase;
                        time_next  = first_slot.time_cnt;
                        bit_next   = first_slot.bit_idx;
                        shift_next = first_slot.shift;
                        done_next  = first_slot.done;
                    end
                    CMD_READ: begin
                        bit_next   = 3'd0;
                        shift_next = '0;
                        if (cfg.read_low_time != '0) begin
                            phase_next = PH_RD_LOW;
                            time_next  = {2'b00, cfg.read_low_time};
                        end else begin
                            phase_next = PH_RD_SAMPLE;
                            time_next  = '0;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end else if (item.kind == KIND_TICK) begin
            unique case (phase_reg)
                PH_RST_LOW: begin
                    if (expire) begin
                        phase_next = PH_WAIT_LOW;
                        time_next  = {2'b00, cfg.presence_delay};
                        poll_next  = '0;
                    end else begin
                        time_next = time_dec;
                    end
                end
                PH_RST_FAIL: begin
                    if (expire) begin
                        phase_next    = PH_IDLE;
                        time_next     = '0;
                        presence_next = 1'b0;
                        done_next     = 1'b1;
                    end else begin
                        time_next = time_dec;
                    end
                end
                PH_WAIT_LOW, PH_WAIT_HIGH: begin
                    if (!expire) begin
                        time_next = time_dec;
                    end else if (phase_reg == PH_WAIT_LOW && !item.line_level) begin
                        phase_next = PH_WAIT_HIGH;
                        poll_next  = '0;
                        time_next  = '0;
                    end else if (phase_reg == PH_WAIT_HIGH && item.line_level) begin
                        phase_next    = PH_IDLE;
                        presence_next = 1'b1;
                        done_next     = 1'b1;
                    end else begin
                        time_next = {2'b00, cfg.poll_interval};
                        if (poll_reg >= ((phase_reg == PH_WAIT_LOW) ? LOW_POLL_LIMIT
                                                                    : HIGH_POLL_LIMIT)) begin
                            phase_next = PH_RST_FAIL;
                        end else begin
                            poll_next = poll_reg + 5'd1;
                        end
                    end
                end
                PH_WR_LOW, PH_WR_HIGH: begin
                    if (!expire) begin
                        time_next = time_dec;
                    end else if (phase_reg == PH_WR_LOW && wr_rel != 8'd0) begin
                        phase_next = PH_WR_HIGH;
                        time_next  = {2'b00, wr_rel};
                    end else if (bit_reg == 3'd7) begin
                        phase_next = PH_IDLE;
                        time_next  = '0;
                        done_next  = 1'b1;
                    end else begin
                        phase_next = follow_slot.phase;
                        time_next  = follow_slot.time_cnt;
                        bit_next   = follow_slot.bit_idx;
                        shift_next = follow_slot.shift;
                        done_next  = follow_slot.done;
                    end
                end
                PH_RD_LOW: begin
                    if (expire) begin
                        phase_next = PH_RD_SAMPLE;
                        time_next  = '0;
                    end else begin
                        time_next = time_dec;
                    end
                end
                PH_RD_SAMPLE, PH_RD_REC: begin
                    if (phase_reg == PH_RD_SAMPLE) begin
                        shift_next = sampled;
                    end
                    if (phase_reg == PH_RD_SAMPLE && READ_REC_LOAD != '0) begin
                        phase_next = PH_RD_REC;
                        time_next  = READ_REC_LOAD;
                    end else if (phase_reg == PH_RD_REC && !expire) begin
                        time_next = time_dec;
                    end else if (bit_reg == 3'd7) begin
                        phase_next     = PH_IDLE;
                        time_next      = '0;
                        last_read_next = shift_next;
                        done_next      = 1'b1;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                        if (cfg.read_low_time != '0) begin
                            phase_next = PH_RD_LOW;
                            time_next  = {2'b00, cfg.read_low_time};
                        end else begin
                            phase_next = PH_RD_SAMPLE;
                            time_next  = '0;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // result for this item
    always_comb begin
        res.drive_low  = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                         (phase_next == PH_RD_LOW);
        res.busy       = (phase_next != PH_IDLE);
        res.done       = done_next;
        res.presence   = presence_next;
        res.read_value = last_read_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            time_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            poll_reg      <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            time_reg      <= time_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            poll_reg      <= poll_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/one_wire_bus_master.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// input     | s_valid / s_ready     | s_kind s_command s_write_value s_line_level
// result    | m_valid / m_ready     | m_drive_low m_busy_res m_done_res m_presence
//           |                       | m_read_value
// config    | cfg_valid / cfg_ready | cfg_index cfg_data
//
// one item per cycle sustained while m_ready holds; an item is registered, then its result
// is computed and registered.
// the bus sequencer updates once per item, a single pass through its next-state logic.
// reset restores the timing registers to defaults and idles the sequencer.
// a stalled result holds; the input register takes one more item before s_ready drops.
`default_nettype none

module one_wire_bus_master (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic                               s_kind,
    input  wire logic [1:0]                         s_command,
    input  wire logic [7:0]                         s_write_value,
    input  wire logic                               s_line_level,
    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic                               m_drive_low,
    output      logic                               m_busy_res,
    output      logic                               m_done_res,
    output      logic                               m_presence,
    output      logic [7:0]                         m_read_value,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import owbm_pkg::*;

`include "one_wire_bus_master_assert.svh"

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    result_t res;
    logic    out_free;
    logic    step;
    logic    s_take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_ready;
    assign step      = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign s_take    = s_valid && s_ready;

    owbm_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owbm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_take) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= '{kind: s_kind, command: s_command,
                             write_value: s_write_value, line_level: s_line_level};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_drive_low  = out_res_reg.drive_low;
    assign m_busy_res   = out_res_reg.busy;
    assign m_done_res   = out_res_reg.done;
    assign m_presence   = out_res_reg.presence;
    assign m_read_value = out_res_reg.read_value;

    `OWBM_ASSERT_NEXT(a_item_kept, aclk, aresetn, in_vld_reg && !out_free, in_vld_reg)
    `OWBM_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, step, out_vld_reg)
    `OWBM_ASSERT_SAME(a_done_idle, aclk, aresetn, step && res.done,
                      !res.busy && !res.drive_low)
    `OWBM_ASSERT_SAME(a_drive_busy, aclk, aresetn, step && res.drive_low, res.busy)

endmodule

`default_nettype wire
